// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, removed when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define ASSERT_AT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ===== rtl/core/tdc_pkg.sv =====
// ----------------------------------------------------------------------------
// tdc_pkg
// shared types, constants and decode functions of the time-of-day clock
// ----------------------------------------------------------------------------
package tdc_pkg;

	localparam logic [15:0] TpsReset    = 16'd1000;
	localparam logic [7:0]  ScanReset   = 8'd2;
	localparam logic [5:0]  SecReset    = 6'd55;
	localparam logic [5:0]  MinReset    = 6'd59;
	localparam logic [4:0]  HourReset   = 5'd23;
	localparam logic [6:0]  SecPerMin   = 7'd60;
	localparam logic [6:0]  MinPerHour  = 7'd60;
	localparam logic [5:0]  HoursPerDay = 6'd24;

	localparam logic [6:0]  SegDash     = 7'h40;
	localparam logic [6:0]  SegOne      = 7'h06;

	localparam logic [2:0]  PosDashA    = 3'd2;
	localparam logic [2:0]  PosDashB    = 3'd5;
	localparam logic [2:0]  PosHourTens = 3'd0;
	localparam logic [2:0]  PosHourOnes = 3'd1;
	localparam logic [2:0]  PosMinTens  = 3'd3;
	localparam logic [2:0]  PosMinOnes  = 3'd4;
	localparam logic [2:0]  PosSecTens  = 3'd6;

	localparam logic [4:0]  DigitSelDashA = 5'd20;
	localparam logic [4:0]  DigitSelDashB = 5'd8;

	typedef enum logic {
		REG_TPS  = 1'b0,
		REG_SCAN = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
		logic       mode;
		logic [2:0] pos;
	} tdc_view_t;

	typedef struct packed {
		logic [3:0] tens;
		logic [3:0] ones;
	} dec_t;

	// split a value below 64 into decimal digits
	function automatic dec_t split_dec(logic [5:0] v);
		dec_t       d;
		logic [5:0] base;
		d.tens = 4'd0;
		base   = 6'd0;
		priority if (v >= 6'd60) begin
			d.tens = 4'd6;
			base   = 6'd60;
		end else if (v >= 6'd50) begin
			d.tens = 4'd5;
			base   = 6'd50;
		end else if (v >= 6'd40) begin
			d.tens = 4'd4;
			base   = 6'd40;
		end else if (v >= 6'd30) begin
			d.tens = 4'd3;
			base   = 6'd30;
		end else if (v >= 6'd20) begin
			d.tens = 4'd2;
			base   = 6'd20;
		end else if (v >= 6'd10) begin
			d.tens = 4'd1;
			base   = 6'd10;
		end else begin
			d.tens = 4'd0;
			base   = 6'd0;
		end
		d.ones = 4'(v - base);
		return d;
	endfunction

	function automatic logic [6:0] seg_of_digit(logic [3:0] d);
		logic [6:0] s;
		unique case (d)
			4'd0:    s = 7'h3f;
			4'd1:    s = 7'h06;
			4'd2:    s = 7'h5b;
			4'd3:    s = 7'h4f;
			4'd4:    s = 7'h66;
			4'd5:    s = 7'h6d;
			4'd6:    s = 7'h7d;
			4'd7:    s = 7'h07;
			4'd8:    s = 7'h7f;
			4'd9:    s = 7'h6f;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/core/tdc_time_core.sv =====
// ----------------------------------------------------------------------------
// tdc_time_core
// prescaler, hh:mm:ss cascade, mode toggle and digit scan counters
// ----------------------------------------------------------------------------
module tdc_time_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              key,
	input  logic [15:0]       tps,
	input  logic [7:0]        scan_int,
	output tdc_pkg::tdc_view_t view
);
	import tdc_pkg::*;

	logic [15:0] tick_q;
	logic [5:0]  sec_q;
	logic [5:0]  min_q;
	logic [4:0]  hour_q;
	logic        mode_q;
	logic        key_q;
	logic [2:0]  pos_q;
	logic [7:0]  scan_q;

	logic [16:0] tick_inc;
	logic        tick_wrap;
	logic [15:0] tick_n;
	logic [6:0]  sec_inc;
	logic [6:0]  min_inc;
	logic [5:0]  hour_inc;
	logic [5:0]  sec_n;
	logic [5:0]  min_n;
	logic [4:0]  hour_n;
	logic        mode_n;
	logic [8:0]  scan_inc;
	logic        scan_wrap;
	logic [7:0]  scan_n;
	logic [2:0]  pos_n;

	always_comb begin
		mode_n   = mode_q ^ (key & ~key_q);

		tick_inc  = {1'b0, tick_q} + 17'd1;
		tick_wrap = tick_inc >= {1'b0, tps};
		tick_n    = tick_wrap ? 16'd0 : tick_inc[15:0];

		sec_inc  = {1'b0, sec_q} + 7'd1;
		min_inc  = {1'b0, min_q} + 7'd1;
		hour_inc = {1'b0, hour_q} + 6'd1;
		sec_n    = sec_q;
		min_n    = min_q;
		hour_n   = hour_q;
		if (tick_wrap) begin
			if (sec_inc >= SecPerMin) begin
				sec_n = 6'd0;
				if (min_inc >= MinPerHour) begin
					min_n  = 6'd0;
					hour_n = (hour_inc >= HoursPerDay) ? 5'd0 : hour_inc[4:0];
				end else begin
					min_n = min_inc[5:0];
				end
			end else begin
				sec_n = sec_inc[5:0];
			end
		end

		scan_inc  = {1'b0, scan_q} + 9'd1;
		scan_wrap = scan_inc >= {1'b0, scan_int};
		scan_n    = scan_wrap ? 8'd0 : scan_inc[7:0];
		pos_n     = scan_wrap ? pos_q + 3'd1 : pos_q;

		view.hours   = hour_n;
		view.minutes = min_n;
		view.seconds = sec_n;
		view.mode    = mode_n;
		view.pos     = pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= 16'd0;
			sec_q  <= SecReset;
			min_q  <= MinReset;
			hour_q <= HourReset;
			mode_q <= 1'b0;
			key_q  <= 1'b0;
			pos_q  <= 3'd0;
			scan_q <= 8'd0;
		end else if (accept) begin
			tick_q <= tick_n;
			sec_q  <= sec_n;
			min_q  <= min_n;
			hour_q <= hour_n;
			mode_q <= mode_n;
			key_q  <= key;
			pos_q  <= pos_n;
			scan_q <= scan_n;
		end
	end

endmodule

// ===== rtl/core/tdc_seg_decode.sv =====
// ----------------------------------------------------------------------------
// tdc_seg_decode
// digit select and seven-segment pattern for the current scan position
// ----------------------------------------------------------------------------
module tdc_seg_decode (
	input  tdc_pkg::tdc_view_t view,
	output logic [4:0]         digit_sel,
	output logic [6:0]         seg
);
	import tdc_pkg::*;

	dec_t hour_d;
	dec_t min_d;
	dec_t sec_d;

	always_comb begin
		hour_d    = split_dec({1'b0, view.hours});
		min_d     = split_dec(view.minutes);
		sec_d     = split_dec(view.seconds);
		// (7 - pos) * 4
		digit_sel = {~view.pos, 2'b00};

		priority if (view.pos == PosDashA || view.pos == PosDashB) begin
			seg = SegDash;
		end else if (view.mode) begin
			seg = SegOne;
		end else begin
			priority case (view.pos)
				PosHourTens: seg = seg_of_digit(hour_d.tens);
				PosHourOnes: seg = seg_of_digit(hour_d.ones);
				PosMinTens:  seg = seg_of_digit(min_d.tens);
				PosMinOnes:  seg = seg_of_digit(min_d.ones);
				PosSecTens:  seg = seg_of_digit(sec_d.tens);
				default:     seg = seg_of_digit(sec_d.ones);
			endcase
		end
	end

endmodule

// ===== rtl/core/time_of_day_clock_seven_segment_scan.sv =====
// ----------------------------------------------------------------------------
// time_of_day_clock_seven_segment_scan
// 24-hour clock with an eight-digit multiplexed seven-segment scan
// ----------------------------------------------------------------------------
// Each request is one tick carrying the debounced key level. The block takes
// one request per cycle unless a held result stalls, and the result register
// gives one result per request in the cycle after it is taken; a new request
// is taken while the held result leaves in the same cycle. A rising key edge
// toggles between the HH-MM-SS view and the fixed 11-11-11 pattern. Zero in
// ticks_per_second (0x0) or scan_interval (0x4) acts as one; the user must
// write them over APB only while no request is outstanding (not enforced).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module time_of_day_clock_seven_segment_scan (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic        key_pressed,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  digit_select,
	output logic [6:0]  segment_code,
	output logic [4:0]  hours,
	output logic [5:0]  minutes,
	output logic [5:0]  seconds,
	output logic        display_mode
);
	import tdc_pkg::*;

	logic [15:0] tps_q;
	logic [7:0]  scan_int_q;
	reg_idx_t    reg_idx;
	logic        cfg_wr;

	logic        accept;
	tdc_view_t   view;
	logic [4:0]  digit_sel;
	logic [6:0]  seg;

	logic        out_valid_q;
	logic [4:0]  digit_sel_q;
	logic [6:0]  seg_q;
	logic [4:0]  hours_q;
	logic [5:0]  minutes_q;
	logic [5:0]  seconds_q;
	logic        mode_q;

	// config registers
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q      <= TpsReset;
			scan_int_q <= ScanReset;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_TPS:  tps_q      <= pwdata[15:0];
				REG_SCAN: scan_int_q <= pwdata[7:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TPS:  prdata = {16'd0, tps_q};
			REG_SCAN: prdata = {24'd0, scan_int_q};
		endcase
	end

	// datapath
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	tdc_time_core u_time_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.key      (key_pressed),
		.tps      (tps_q),
		.scan_int (scan_int_q),
		.view     (view)
	);

	tdc_seg_decode u_seg_decode (
		.view      (view),
		.digit_sel (digit_sel),
		.seg       (seg)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_sel_q <= 5'd0;
			seg_q       <= 7'd0;
			hours_q     <= 5'd0;
			minutes_q   <= 6'd0;
			seconds_q   <= 6'd0;
			mode_q      <= 1'b0;
		end else if (accept) begin
			digit_sel_q <= digit_sel;
			seg_q       <= seg;
			hours_q     <= view.hours;
			minutes_q   <= view.minutes;
			seconds_q   <= view.seconds;
			mode_q      <= view.mode;
		end
	end

	assign out_valid    = out_valid_q;
	assign digit_select = digit_sel_q;
	assign segment_code = seg_q;
	assign hours        = hours_q;
	assign minutes      = minutes_q;
	assign seconds      = seconds_q;
	assign display_mode = mode_q;

	// checks
	`ASSERT_NEVER(a_no_overwrite, clk, arst_n, accept && out_valid_q && !out_ready)
	`ASSERT_NEVER(a_time_range, clk, arst_n, out_valid && (hours > 5'd23 || minutes > 6'd59 || seconds > 6'd59))
	`ASSERT_AT(a_mode_hold, clk, arst_n, !accept |=> $stable(display_mode))
	`ASSERT_AT(a_dash_digit, clk, arst_n, out_valid && (digit_select == DigitSelDashA || digit_select == DigitSelDashB) |-> segment_code == SegDash)

endmodule

// ===== sim/time_of_day_clock_seven_segment_scan_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_of_day_clock_seven_segment_scan_test
// ----------------------------------------------------------------------------
// Self-checking bench for the time-of-day clock with its multiplexed display
// scan. Tick requests go in over a valid/ready channel, both sides idle at
// random, and every result is checked field by field against a local
// prediction of the clock, the key mode toggle and the digit scan. The APB
// registers are written between phases, at the extremes and at random, and
// read back. Directed cases cover midnight wrap, held keys, zero registers and
// limits lowered below a running count; a long random part follows.
// ----------------------------------------------------------------------------
module time_of_day_clock_seven_segment_scan_test;
	import tdc_pkg::*;

	typedef struct {
		logic [4:0] digit_select;
		logic [6:0] segment_code;
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
		logic       display_mode;
	} scan_result_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	logic        key_pressed;
	logic        out_valid;
	logic        out_ready;
	logic [4:0]  digit_select;
	logic [6:0]  segment_code;
	logic [4:0]  hours;
	logic [5:0]  minutes;
	logic [5:0]  seconds;
	logic        display_mode;

	time_of_day_clock_seven_segment_scan u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.key_pressed  (key_pressed),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.digit_select (digit_select),
		.segment_code (segment_code),
		.hours        (hours),
		.minutes      (minutes),
		.seconds      (seconds),
		.display_mode (display_mode)
	);

	// clock model state
	logic [15:0] tps_reg;
	logic [7:0]  scan_reg;
	logic [15:0] tick_cnt;
	logic [5:0]  sec_cnt;
	logic [5:0]  min_cnt;
	logic [4:0]  hour_cnt;
	logic        mode_q;
	logic        key_q;
	logic [2:0]  pos_q;
	logic [7:0]  scan_cnt;

	scan_result_t expected_scan[$];
	int          error_count;
	int          tick_count_sent;
	int          reg_write_count;
	int          toggle_count;
	bit          no_idle;
	int          stall_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("timeout");
		$display("Mismatches found");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [6:0] digit_glyph(int unsigned d);
		case (d)
			0: return 7'h3f;
			1: return 7'h06;
			2: return 7'h5b;
			3: return 7'h4f;
			4: return 7'h66;
			5: return 7'h6d;
			6: return 7'h7d;
			7: return 7'h07;
			8: return 7'h7f;
			default: return 7'h6f;
		endcase
	endfunction

	function automatic scan_result_t predict_tick(logic key);
		scan_result_t r;
		int unsigned  nxt;
		if (key && !key_q) begin
			mode_q = ~mode_q;
			toggle_count++;
		end
		key_q = key;
		nxt = int'(tick_cnt) + 1;
		if (nxt >= int'(tps_reg)) begin
			tick_cnt = '0;
			if (sec_cnt == 6'd59) begin
				sec_cnt = '0;
				if (min_cnt == 6'd59) begin
					min_cnt = '0;
					hour_cnt = (hour_cnt == 5'd23) ? 5'd0 : hour_cnt + 5'd1;
				end else begin
					min_cnt = min_cnt + 6'd1;
				end
			end else begin
				sec_cnt = sec_cnt + 6'd1;
			end
		end else begin
			tick_cnt = 16'(nxt);
		end
		r.digit_select = 5'((7 - int'(pos_q)) * 4);
		if (pos_q == PosDashA || pos_q == PosDashB)
			r.segment_code = SegDash;
		else if (mode_q)
			r.segment_code = SegOne;
		else begin
			case (pos_q)
				PosHourTens: r.segment_code = digit_glyph(int'(hour_cnt) / 10);
				PosHourOnes: r.segment_code = digit_glyph(int'(hour_cnt) % 10);
				PosMinTens:  r.segment_code = digit_glyph(int'(min_cnt) / 10);
				PosMinOnes:  r.segment_code = digit_glyph(int'(min_cnt) % 10);
				PosSecTens:  r.segment_code = digit_glyph(int'(sec_cnt) / 10);
				default:     r.segment_code = digit_glyph(int'(sec_cnt) % 10);
			endcase
		end
		r.hours        = hour_cnt;
		r.minutes      = min_cnt;
		r.seconds      = sec_cnt;
		r.display_mode = mode_q;
		nxt = int'(scan_cnt) + 1;
		if (nxt >= int'(scan_reg)) begin
			scan_cnt = '0;
			pos_q    = pos_q + 3'd1;
		end else begin
			scan_cnt = 8'(nxt);
		end
		return r;
	endfunction

	task automatic send_request(logic key);
		int gap;
		@(negedge clk);
		in_valid    = 1'b1;
		key_pressed = key;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
		expected_scan.push_back(predict_tick(key));
		tick_count_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_scan.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic reg_read_check(reg_idx_t idx, logic [31:0] want);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = 3'({idx, 2'b00});
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata !== want) begin
			$error("prdata reg %0d expected %0d actual %0d", idx, want, prdata);
			error_count++;
		end
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic reg_write(reg_idx_t idx, logic [31:0] data);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = 3'({idx, 2'b00});
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (idx == REG_TPS)
			tps_reg = data[15:0];
		else
			scan_reg = data[7:0];
		reg_write_count++;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		reg_read_check(idx, (idx == REG_TPS) ? {16'd0, tps_reg} : {24'd0, scan_reg});
	endtask

	task automatic set_regs(logic [15:0] tps, logic [7:0] scan, bit junk);
		reg_write(REG_TPS, {junk ? 16'($urandom) : 16'd0, tps});
		reg_write(REG_SCAN, {junk ? 24'($urandom) : 24'd0, scan});
	endtask

	// result checker
	always @(posedge clk) begin
		scan_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_scan.size() == 0) begin
				$error("result with nothing expected");
				error_count++;
			end else begin
				e = expected_scan.pop_front();
				if (digit_select !== e.digit_select) begin
					$error("digit_select expected %0d actual %0d", e.digit_select, digit_select);
					error_count++;
				end
				if (segment_code !== e.segment_code) begin
					$error("segment_code expected %0h actual %0h", e.segment_code, segment_code);
					error_count++;
				end
				if (hours !== e.hours) begin
					$error("hours expected %0d actual %0d", e.hours, hours);
					error_count++;
				end
				if (minutes !== e.minutes) begin
					$error("minutes expected %0d actual %0d", e.minutes, minutes);
					error_count++;
				end
				if (seconds !== e.seconds) begin
					$error("seconds expected %0d actual %0d", e.seconds, seconds);
					error_count++;
				end
				if (display_mode !== e.display_mode) begin
					$error("display_mode expected %0d actual %0d", e.display_mode, display_mode);
					error_count++;
				end
			end
		end
	end

	// receiver stalls
	initial begin
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else begin
				out_ready  = 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	task automatic test_reset_values();
		reg_read_check(REG_TPS, {16'd0, TpsReset});
		reg_read_check(REG_SCAN, {24'd0, ScanReset});
		repeat (4) send_request(1'b0);
		drain();
	endtask

	task automatic test_midnight_wrap();
		set_regs(16'd1, 8'd1, 1'b0);
		repeat (8) send_request(1'b0);
		drain();
	endtask

	task automatic test_mode_key();
		// held key toggles once, release and press again toggles back
		send_request(1'b1);
		send_request(1'b1);
		send_request(1'b1);
		send_request(1'b0);
		send_request(1'b1);
		send_request(1'b0);
		drain();
	endtask

	task automatic test_zero_registers();
		set_regs(16'd0, 8'd0, 1'b1);
		repeat (3) send_request(1'b0);
		drain();
	endtask

	task automatic test_lowered_limit();
		set_regs(16'hffff, 8'hff, 1'b0);
		repeat (3) send_request(1'b0);
		drain();
		// counts now sit above the new limits
		set_regs(16'd2, 8'd2, 1'b0);
		send_request(1'b1);
		send_request(1'b0);
		drain();
	endtask

	task automatic test_random();
		logic [15:0] tps;
		logic [7:0]  scan;
		logic        key;
		key = 1'b0;
		for (int p = 0; p < 7; p++) begin
			case (p)
				0: begin
					tps  = 16'd1;
					scan = 8'd1;
				end
				1: begin
					tps  = 16'hffff;
					scan = 8'hff;
				end
				2: begin
					tps  = 16'd0;
					scan = 8'd0;
				end
				default: begin
					case ($urandom_range(0, 2))
						0: tps = 16'($urandom_range(1, 4));
						1: tps = 16'($urandom_range(5, 60));
						default: tps = 16'($urandom);
					endcase
					scan = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 8)) : 8'($urandom);
				end
			endcase
			no_idle = (p == 0) || ($urandom_range(0, 3) == 0);
			set_regs(tps, scan, 1'b1);
			repeat (200) begin
				if ($urandom_range(0, 3) == 0)
					key = ~key;
				send_request(key);
			end
			drain();
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		in_valid    = 1'b0;
		key_pressed = 1'b0;
		out_ready   = 1'b0;
		no_idle     = 1'b0;
		error_count = 0;
		tick_count_sent = 0;
		reg_write_count = 0;
		toggle_count    = 0;
		tps_reg  = TpsReset;
		scan_reg = ScanReset;
		tick_cnt = '0;
		sec_cnt  = SecReset;
		min_cnt  = MinReset;
		hour_cnt = HourReset;
		mode_q   = 1'b0;
		key_q    = 1'b0;
		pos_q    = '0;
		scan_cnt = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		test_reset_values();
		test_midnight_wrap();
		test_mode_key();
		test_zero_registers();
		test_lowered_limit();
		test_random();

		$display("ran %0d ticks across %0d register writes, %0d mode toggles",
			tick_count_sent, reg_write_count, toggle_count);
		if (error_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== time_of_day_clock_seven_segment_scan.f =====
+incdir+rtl/core
rtl/core/tdc_pkg.sv
rtl/core/tdc_time_core.sv
rtl/core/tdc_seg_decode.sv
rtl/core/time_of_day_clock_seven_segment_scan.sv
sim/time_of_day_clock_seven_segment_scan_test.sv
